// ----- hdl/positional_array_insert_delete_top_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the positional list block
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_INSERT_DELETE_TOP_DEFINES_SVH
`define POSITIONAL_ARRAY_INSERT_DELETE_TOP_DEFINES_SVH

// Condition in the same cycle as the trigger.
`define PAI_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Condition in the cycle after the trigger.
`define PAI_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- hdl/pai_pkg.sv -----
// ---------------------------------------------------------------------------
// pai_pkg
// Types and codes shared by the positional list block.
// ---------------------------------------------------------------------------
package pai_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int COUNT_W = 8;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT,
    S_WRVAL,
    S_RDWAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t                    status;
    logic signed [VALUE_W-1:0]  read_value;
    logic [COUNT_W-1:0]         entry_count;
  } res_t;

endpackage

// ----- hdl/pai_mem.sv -----
// ---------------------------------------------------------------------------
// pai_mem
// Entry store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module pai_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [pai_pkg::VALUE_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [pai_pkg::VALUE_W-1:0] rdata
);
  import pai_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/pai_ctrl.sv -----
// ---------------------------------------------------------------------------
// pai_ctrl
// Command sequencer: checks each command against the count and moves
// entries through the store one per cycle for insert and delete.
// ---------------------------------------------------------------------------
module pai_ctrl #(
  parameter int CAPACITY = 128,
  parameter int AW       = 7,
  parameter int CW       = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_cmd,
  input  logic [pai_pkg::POS_W-1:0]    in_position,
  input  logic signed [pai_pkg::VALUE_W-1:0] in_value,
  output logic                         res_valid,
  input  logic                         res_ready,
  output pai_pkg::res_t                res,
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output logic [pai_pkg::VALUE_W-1:0]  mem_wdata,
  output logic                         mem_re,
  output logic [AW-1:0]                mem_raddr,
  input  logic [pai_pkg::VALUE_W-1:0]  mem_rdata
);
  import pai_pkg::*;

  localparam int PW = (CW > POS_W) ? CW : POS_W;

  state_t              state_r, state_nxt;
  logic [1:0]          cmd_r, cmd_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  status_t             status_r, status_nxt;
  logic [VALUE_W-1:0]  rval_r, rval_nxt;

  logic [PW-1:0]       pos_ext, cnt_ext;
  logic [CW-1:0]       cnt_dec, cnt_inc;
  logic [AW-1:0]       pos_a, cnt_m1;
  logic                is_full, is_empty, is_ins, shift_last;

  assign pos_ext  = PW'(pos_r);
  assign cnt_ext  = PW'(count_r);
  assign cnt_dec  = count_r - CW'(1);
  assign cnt_inc  = count_r + CW'(1);
  assign pos_a    = pos_ext[AW-1:0];
  assign cnt_m1   = cnt_dec[AW-1:0];
  assign is_full  = (count_r == CW'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign is_ins   = (cmd_r == CMD_INSERT);
  // insert walks down to the position, delete walks up to the last entry
  assign shift_last = is_ins ? (idx_r == pos_a) : (idx_r == cnt_m1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_INSERT: begin
            if (!is_full && pos_ext == cnt_ext) state_nxt = S_WRVAL;
            else if (!is_full && pos_ext < cnt_ext) state_nxt = S_SHIFT;
          end
          CMD_DELETE: begin
            if (!is_empty && pos_ext < PW'(cnt_m1)) state_nxt = S_SHIFT;
          end
          CMD_READ: begin
            if (!is_empty && pos_ext < cnt_ext) state_nxt = S_RDWAIT;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SHIFT: begin
        if (shift_last) state_nxt = is_ins ? S_WRVAL : S_DONE;
      end
      S_WRVAL:  state_nxt = S_DONE;
      S_RDWAIT: state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cmd_nxt    = cmd_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    rval_nxt   = rval_r;
    mem_we     = 1'b0;
    mem_waddr  = pos_a;
    mem_wdata  = val_r;
    mem_re     = 1'b0;
    mem_raddr  = pos_a;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt = in_cmd;
          pos_nxt = in_position;
          val_nxt = in_value;
        end
      end
      S_CHECK: begin
        rval_nxt   = '0;
        status_nxt = ST_BADPOS;
        case (cmd_r)
          CMD_INSERT: begin
            if (is_full) begin
              status_nxt = ST_FULL;
            end else if (pos_ext < cnt_ext) begin
              mem_re    = 1'b1;
              mem_raddr = cnt_m1;
              idx_nxt   = cnt_m1;
            end
          end
          CMD_DELETE: begin
            if (is_empty) begin
              status_nxt = ST_EMPTY;
            end else if (pos_ext < PW'(cnt_m1)) begin
              mem_re    = 1'b1;
              mem_raddr = pos_a + AW'(1);
              idx_nxt   = pos_a + AW'(1);
            end else if (pos_ext == PW'(cnt_m1)) begin
              // last entry: nothing to move
              status_nxt = ST_OK;
              count_nxt  = cnt_dec;
            end
          end
          CMD_READ: begin
            if (is_empty) begin
              status_nxt = ST_EMPTY;
            end else if (pos_ext < cnt_ext) begin
              mem_re = 1'b1;
            end
          end
          default: status_nxt = ST_BADPOS;
        endcase
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        mem_waddr = is_ins ? (idx_r + AW'(1)) : (idx_r - AW'(1));
        if (!shift_last) begin
          mem_re    = 1'b1;
          mem_raddr = is_ins ? (idx_r - AW'(1)) : (idx_r + AW'(1));
          idx_nxt   = mem_raddr;
        end else if (!is_ins) begin
          status_nxt = ST_OK;
          count_nxt  = cnt_dec;
        end
      end
      S_WRVAL: begin
        mem_we     = 1'b1;
        status_nxt = ST_OK;
        count_nxt  = cnt_inc;
      end
      S_RDWAIT: begin
        status_nxt = ST_OK;
        rval_nxt   = mem_rdata;
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign res.status      = status_r;
  assign res.read_value  = rval_r;
  assign res.entry_count = cnt_ext[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    rval_r   <= rval_nxt;
  end

endmodule

// ----- hdl/positional_array_insert_delete_top.sv -----
// ---------------------------------------------------------------------------
// positional_array_insert_delete_top
// Ordered list of signed 32-bit entries with insert, delete and read at a
// position, held in a single-port-write / single-port-read memory.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   in      | in_valid / in_ready  | in_cmd, in_position, in_value
//   out     | out_valid / out_ready| out_status, out_read_value,
//           |                      | out_entry_count
//
// Insert and delete move one entry per cycle through the single write port.
// One command is in work at a time. Reset clears the state, the count and
// the output valid flag only; entries are written before they are read.
// A finished result waits in the output register; the next command is
// taken meanwhile, but its result holds until the register is free.
// ---------------------------------------------------------------------------
module positional_array_insert_delete_top #(
  parameter int CAPACITY = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_cmd,
  input  logic [pai_pkg::POS_W-1:0]          in_position,
  input  logic signed [pai_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_status,
  output logic signed [pai_pkg::VALUE_W-1:0] out_read_value,
  output logic [pai_pkg::COUNT_W-1:0]        out_entry_count
);
  import pai_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic               res_valid, res_ready;
  res_t               res;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [VALUE_W-1:0] mem_wdata, mem_rdata;

  logic               out_valid_r;
  res_t               out_r;

  pai_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_position (in_position),
    .in_value    (in_value),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  pai_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_read_value  = out_r.read_value;
  assign out_entry_count = out_r.entry_count;

endmodule

// ----- hdl/pai_checker.sv -----
// ---------------------------------------------------------------------------
// pai_checker
// Port-level checks on the positional list block, bound to the top level.
// ---------------------------------------------------------------------------
`include "positional_array_insert_delete_top_defines.svh"

module pai_checker #(
  parameter int CAPACITY = 128
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [1:0]                         out_status,
  input logic signed [pai_pkg::VALUE_W-1:0] out_read_value,
  input logic [pai_pkg::COUNT_W-1:0]        out_entry_count
);
  import pai_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam int PW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [PW-1:0] CAP_E = PW'(CAP_C);
  localparam logic [COUNT_W-1:0] CAP_LOW = CAP_E[COUNT_W-1:0];

  `PAI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_read_value) &&
    $stable(out_entry_count), "stalled result changed")

  `PAI_ASSERT_NEXT(a_one_cmd, in_valid && in_ready, !in_ready,
    "second command taken while one is in work")

  `PAI_ASSERT_SAME(a_fail_zero, out_valid && out_status != ST_OK,
    out_read_value == '0, "failed command returned a nonzero value")

  `PAI_ASSERT_SAME(a_full_cnt, out_valid && out_status == ST_FULL,
    out_entry_count == CAP_LOW, "full status with count below capacity")

  `PAI_ASSERT_SAME(a_empty_cnt, out_valid && out_status == ST_EMPTY,
    out_entry_count == '0, "empty status with nonzero count")

endmodule

bind positional_array_insert_delete_top pai_checker #(.CAPACITY(CAPACITY)) u_pai_checker (.*);

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: positional list insert / delete / read testbench
// Drives insert, delete and read commands with random handshake gaps and
// checks every result against a local model of the list and its count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pai_pkg::*;

  localparam int CAP          = 128;
  localparam int RANDOM_ITEMS = 1700;
  localparam int STALL_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 2 * CAP;

  typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIX} mix_mode_t;

  // Local model of the list plus the queue of results still owed by the block.
  class list_scoreboard;
    logic signed [VALUE_W-1:0] slots [CAP];
    int unsigned               held;
    res_t                      owed_q[$];
    int                        mismatches;

    function new();
      held       = 0;
      mismatches = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void note_input(logic [1:0] cmd, logic [POS_W-1:0] pos,
                             logic signed [VALUE_W-1:0] val);
      res_t r;
      int   i;
      r.status     = ST_OK;
      r.read_value = '0;
      case (cmd)
        CMD_INSERT: begin
          if (held >= CAP) begin
            r.status = ST_FULL;
          end else if (pos > held) begin
            r.status = ST_BADPOS;
          end else begin
            for (i = held; i > pos; i--) slots[i] = slots[i-1];
            slots[pos] = val;
            held++;
          end
        end
        CMD_DELETE: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else if (pos >= held) begin
            r.status = ST_BADPOS;
          end else begin
            for (i = pos; i + 1 < held; i++) slots[i] = slots[i+1];
            held--;
          end
        end
        CMD_READ: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else if (pos >= held) begin
            r.status = ST_BADPOS;
          end else begin
            r.read_value = slots[pos];
          end
        end
        default: r.status = ST_BADPOS;  // unused opcode
      endcase
      r.entry_count = held[COUNT_W-1:0];
      owed_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic signed [VALUE_W-1:0] rv,
                               logic [COUNT_W-1:0] cnt);
      res_t e;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result status %0d value %0d count %0d",
                   $time, st, rv, cnt);
        return;
      end
      e = owed_q.pop_front();
      if (st !== e.status || rv !== e.read_value || cnt !== e.entry_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch status %0d/%0d value %0d/%0d count %0d/%0d (exp/got)",
                   $time, e.status, st, e.read_value, rv, e.entry_count, cnt);
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [1:0]                  in_cmd;
  logic [POS_W-1:0]            in_position;
  logic signed [VALUE_W-1:0]   in_value;
  logic                        out_valid;
  logic                        out_ready;
  logic [1:0]                  out_status;
  logic signed [VALUE_W-1:0]   out_read_value;
  logic [COUNT_W-1:0]          out_entry_count;

  list_scoreboard sb;
  int             sent;
  int             stall_cycles;
  logic           calm;

  positional_array_insert_delete_top #(.CAPACITY(CAP)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure, none during the calm window.
  always @(posedge clk) begin
    if (rst_n) begin
      out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 13);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_read_value, out_entry_count);
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("[positional_array_insert_delete_top] ERROR");
          $finish;
        end
      end
    end
  end

  // Holds valid across back-to-back items; the model is updated on transfer.
  task automatic send_item(input logic [1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic signed [VALUE_W-1:0] val);
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(cmd, pos, val);
    sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Position in 0..hi, biased toward both ends.
  function automatic logic [POS_W-1:0] edge_pos(int unsigned hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 40) return hi[POS_W-1:0];
    return POS_W'($urandom_range(0, hi));
  endfunction

  task automatic random_step(input mix_mode_t mode);
    int                        r;
    int                        ins_w;
    int                        del_w;
    int                        rd_w;
    logic                      quiet;
    logic [1:0]                cmd;
    logic [POS_W-1:0]          pos;
    logic signed [VALUE_W-1:0] val;
    int unsigned               held;
    if (sent == 850) drain_results();
    quiet = (sent >= 700 && sent < 1000);
    calm <= quiet;
    if (!quiet && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    held = sb.held;
    case (mode)
      MODE_GROW:   begin ins_w = 75; del_w = 10; rd_w = 10; end
      MODE_SHRINK: begin ins_w = 10; del_w = 75; rd_w = 10; end
      default:     begin ins_w = 35; del_w = 30; rd_w = 25; end
    endcase
    r = $urandom_range(0, 9);
    case (r)
      0: val = 32'sh8000_0000;
      1: val = 32'sh7fff_ffff;
      2: val = '0;
      3: val = -32'sd1;
      default: val = $urandom;
    endcase
    r = $urandom_range(0, 99);
    if (r < ins_w) begin
      cmd = CMD_INSERT;
      pos = edge_pos(held);
    end else if (r < ins_w + del_w) begin
      cmd = CMD_DELETE;
      pos = (held == 0) ? '0 : edge_pos(held - 1);
    end else if (r < ins_w + del_w + rd_w) begin
      cmd = CMD_READ;
      pos = (held == 0) ? '0 : edge_pos(held - 1);
    end else begin
      cmd = 2'($urandom_range(0, 3));
      pos = POS_W'($urandom_range(0, 255));
    end
    send_item(cmd, pos, val);
  endtask

  initial begin
    int total;
    sb           = new();
    sent         = 0;
    stall_cycles = 0;
    total        = RANDOM_ITEMS;
    rst_n       <= 1'b0;
    calm        <= 1'b0;
    in_valid    <= 1'b0;
    in_cmd      <= '0;
    in_position <= '0;
    in_value    <= '0;
    out_ready   <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list, unused opcode and bad positions first.
    send_item(CMD_READ,   8'd0,   32'sd7);
    send_item(CMD_DELETE, 8'd0,   32'sd7);
    send_item(2'd3,       8'd0,   32'sd1);
    send_item(CMD_INSERT, 8'd1,   32'sd5);
    send_item(CMD_INSERT, 8'd255, 32'sd5);
    // Build [-1, 0, 0x5a5a5a5a, min, max]: end, front and middle inserts.
    send_item(CMD_INSERT, 8'd0,   32'sh8000_0000);
    send_item(CMD_INSERT, 8'd1,   32'sh7fff_ffff);
    send_item(CMD_INSERT, 8'd0,   -32'sd1);
    send_item(CMD_INSERT, 8'd1,   32'sd0);
    send_item(CMD_INSERT, 8'd2,   32'sh5a5a_5a5a);
    for (int i = 0; i < 5; i++) send_item(CMD_READ, i[POS_W-1:0], 32'sd0);
    send_item(CMD_READ,   8'd5,   32'sd0);
    send_item(CMD_READ,   8'd255, 32'sd0);
    send_item(CMD_DELETE, 8'd5,   32'sd0);
    send_item(CMD_DELETE, 8'd2,   32'sd0);
    send_item(CMD_DELETE, 8'd3,   32'sd0);
    send_item(CMD_DELETE, 8'd0,   32'sd0);
    send_item(2'd3,       8'd255, -32'sd1);
    send_item(CMD_READ,   8'd0,   32'sd0);
    send_item(CMD_DELETE, 8'd255, 32'sd0);
    drain_results();

    total = total + sent;
    while (sent < total) begin
      // Fill to capacity and push past it, run a mixed stretch, then empty and push past that.
      while (sb.held < CAP && sent < total) random_step(MODE_GROW);
      repeat (8) random_step(MODE_GROW);
      repeat (80) random_step(MODE_MIX);
      while (sb.held > 0 && sent < total) random_step(MODE_SHRINK);
      repeat (8) random_step(MODE_SHRINK);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[positional_array_insert_delete_top] OK");
    end else begin
      $display("[positional_array_insert_delete_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/pai_pkg.sv
hdl/pai_mem.sv
hdl/pai_ctrl.sv
hdl/positional_array_insert_delete_top.sv
hdl/pai_checker.sv
dv/tb.sv
